// ----- hw/rtl/piecewise_constant_cdf_sampler_defines.svh -----
// Assertion helpers shared by the sampler RTL.
// Each expects signals named clk and rst_n in the enclosing module.
`ifndef PIECEWISE_CONSTANT_CDF_SAMPLER_DEFINES_SVH
`define PIECEWISE_CONSTANT_CDF_SAMPLER_DEFINES_SVH

// Same-cycle implication.
`define PCCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pccs_pkg.sv -----
`timescale 1ns / 1ps

package pccs_pkg;

  localparam int MAX_BINS    = 256;
  localparam int WEIGHT_BITS = 16;

  // Fixed field widths of the channels.
  localparam int FRAC_W   = 16;  // u and x, Q0.16
  localparam int IN_W_W   = 16;  // weight field on the input beat
  localparam int PDF_W    = 25;
  localparam int BIN_W    = 8;

  localparam int IDX_W    = $clog2(MAX_BINS);
  localparam int CNT_W    = IDX_W + 1;
  localparam int SUM_W    = WEIGHT_BITS + IDX_W;       // prefix sums and total
  localparam int MB_W     = (WEIGHT_BITS > FRAC_W) ? WEIGHT_BITS : FRAC_W;
  localparam int MP_W     = SUM_W + MB_W;              // multiplier product
  localparam int TGT_W    = SUM_W + FRAC_W;            // u * total
  localparam int DEN_W    = WEIGHT_BITS + CNT_W;       // divisor width
  localparam int NUM_W    = TGT_W + 1;                 // dividend width
  localparam int XQ_W     = FRAC_W + 1;                // quotient bits for x
  localparam int PQ_W     = CNT_W + FRAC_W;            // quotient bits for pdf
  localparam int STEP_W   = $clog2(PQ_W + 1);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TGT,
    ST_SRCH,
    ST_CMP,
    ST_FETCH,
    ST_NUM,
    ST_DEN,
    ST_XST,
    ST_XDIV,
    ST_PST,
    ST_PDIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

// ----- hw/rtl/pccs_in_if.sv -----
`timescale 1ns / 1ps

interface pccs_in_if import pccs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [IN_W_W-1:0] weight;
  logic              last;
  logic [FRAC_W-1:0] u;

  modport source (output valid, output cmd, output weight, output last, output u,
                  input ready);
  modport sink   (input valid, input cmd, input weight, input last, input u,
                  output ready);
endinterface

// ----- hw/rtl/pccs_out_if.sv -----
`timescale 1ns / 1ps

interface pccs_out_if import pccs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FRAC_W-1:0] x;
  logic [PDF_W-1:0]  pdf;
  logic [BIN_W-1:0]  bin;
  logic              zero_total;

  modport source (output valid, output x, output pdf, output bin, output zero_total,
                  input ready);
  modport sink   (input valid, input x, input pdf, input bin, input zero_total,
                  output ready);
endinterface

// ----- hw/rtl/pccs_ram.sv -----
`timescale 1ns / 1ps

module pccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/pccs_div.sv -----
`timescale 1ns / 1ps
`include "piecewise_constant_cdf_sampler_defines.svh"

// Restoring divider, one quotient bit per cycle. The caller supplies the
// dividend already split: the high part as the starting remainder (it must be
// below the divisor) and the low part left-aligned.
module pccs_div import pccs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  input  logic [DEN_W-1:0] rem0,
  input  logic [PQ_W-1:0]  low,
  input  logic [DEN_W-1:0] den,
  output logic [PQ_W-1:0]  q,
  output div_rsp_t         rsp
);

  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [PQ_W-1:0]   low_r;
  logic [PQ_W-1:0]   q_r;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] cnt_r;
  logic              done_r;
  logic [DEN_W:0]    shifted;
  logic [DEN_W+1:0]  diff;
  logic              qbit;

  always_comb begin
    shifted = {rem_r, low_r[PQ_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_r};
    qbit    = ~diff[DEN_W+1];
    rem_nxt = qbit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= rem0;
      low_r <= low;
      den_r <= den;
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[PQ_W-2:0], 1'b0};
      q_r   <= {q_r[PQ_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == STEP_W'(1));
      if (req.start) begin
        cnt_r <= req.steps;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign q        = q_r;
  assign rsp.busy = (cnt_r != '0);
  assign rsp.done = done_r;

  `PCCS_ASSERT_IMP(a_start_when_free, req.start, !rsp.busy && !rsp.done, "divider restarted while busy")
  `PCCS_ASSERT_IMP(a_done_after_run, rsp.done, !rsp.busy, "divider done while still running")
  `PCCS_ASSERT_NXT(a_start_runs, req.start && req.steps != '0, rsp.busy, "divider start did not begin a run")

endmodule

// ----- hw/rtl/piecewise_constant_cdf_sampler.sv -----
`timescale 1ns / 1ps
`include "piecewise_constant_cdf_sampler_defines.svh"

// Channel  Dir  Beat contents
// in_ch    in   cmd, weight, last, u   (load one weight or run one query)
// out_ch   out  x, pdf, bin, zero_total (one beat per query, none per load)
//
// A load is taken in the idle state and leaves the block there. A query holds
// the block through the search, whose steps on the prefix RAM each pass ST_SRCH
// and ST_CMP, then through the x division and the pdf division. An all-zero
// table skips the pdf division; an empty table goes straight to ST_OUT.
// Reset is synchronous, active low, and clears count, total, closed flag and state.
// Input waits while a query is in flight or its result beat waits on out_ch.ready.
module piecewise_constant_cdf_sampler import pccs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  pccs_in_if.sink    in_ch,
  pccs_out_if.source out_ch
);

  state_t state_r, state_nxt;

  // Table state.
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] tot_r;
  logic             closed_r;

  // Query datapath.
  logic [FRAC_W-1:0]      u_r;
  logic [CNT_W-1:0]       n_r;
  logic                   zero_r;
  logic [TGT_W-1:0]       tgt_r;
  logic [IDX_W-1:0]       lo_r, hi_r, mid_r;
  logic [WEIGHT_BITS-1:0] w_r, wt_r;
  logic [TGT_W-1:0]       num_r;
  logic [SUM_W-1:0]       lw_r;
  logic [NUM_W-1:0]       numx_r;
  logic [DEN_W-1:0]       denx_r;
  logic [DEN_W-1:0]       pn_r;

  // Result beat.
  logic [FRAC_W-1:0] x_r;
  logic [PDF_W-1:0]  pdf_r;
  logic [BIN_W-1:0]  bin_r;
  logic              zt_r;

  logic                   in_acc, load_acc, query_acc;
  logic [CNT_W-1:0]       eff_cnt;
  logic [SUM_W-1:0]       eff_tot, tot_new;
  logic [WEIGHT_BITS-1:0] w_in;
  logic                   load_we;

  logic [IDX_W-1:0]       wram_raddr, pram_raddr;
  logic [WEIGHT_BITS-1:0] wram_rdata;
  logic [SUM_W-1:0]       pram_rdata;

  logic [CNT_W-1:0] span;
  logic [IDX_W-1:0] mid;
  logic [SUM_W-1:0] cum_mid, cum_lo;
  logic [WEIGHT_BITS-1:0] w_sel;

  logic [SUM_W-1:0] mul_a;
  logic [MB_W-1:0]  mul_b;
  logic [MP_W-1:0]  mul_p;

  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic [DEN_W-1:0] div_rem0, div_den;
  logic [PQ_W-1:0]  div_low, div_q;
  logic [NUM_W-1:0] nump;

  // ---------------------------------------------------------------- load path
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign load_acc  = in_acc && (in_ch.cmd == CMD_LOAD);
  assign query_acc = in_acc && (in_ch.cmd == CMD_QUERY);
  assign w_in      = in_ch.weight[WEIGHT_BITS-1:0];

  // A load after a closed table starts a new one from bin zero.
  assign eff_cnt = closed_r ? '0 : cnt_r;
  assign eff_tot = closed_r ? '0 : tot_r;
  assign tot_new = eff_tot + SUM_W'(w_in);
  assign load_we = load_acc && (eff_cnt < CNT_W'(MAX_BINS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      tot_r    <= '0;
      closed_r <= 1'b1;
    end else if (load_acc) begin
      cnt_r    <= load_we ? eff_cnt + 1'b1 : eff_cnt;
      tot_r    <= load_we ? tot_new : eff_tot;
      closed_r <= in_ch.last;
    end
  end

  // Prefix RAM entry k holds the cumulative sum through bin k, i.e. the start
  // of bin k+1. The start of bin zero is always zero and is not stored.
  pccs_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_BINS)) u_wram (
    .clk   (clk),
    .we    (load_we),
    .waddr (eff_cnt[IDX_W-1:0]),
    .wdata (w_in),
    .raddr (wram_raddr),
    .rdata (wram_rdata)
  );

  pccs_ram #(.WIDTH(SUM_W), .DEPTH(MAX_BINS)) u_pram (
    .clk   (clk),
    .we    (load_we),
    .waddr (eff_cnt[IDX_W-1:0]),
    .wdata (tot_new),
    .raddr (pram_raddr),
    .rdata (pram_rdata)
  );

  // ------------------------------------------------------- shared arithmetic
  assign mul_p = MP_W'(mul_a) * MP_W'(mul_b);

  pccs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rem0  (div_rem0),
    .low   (div_low),
    .den   (div_den),
    .q     (div_q),
    .rsp   (div_rsp)
  );

  // Search midpoint rounds up so that raising the lower bound always moves it.
  assign span    = CNT_W'(hi_r) - CNT_W'(lo_r) + CNT_W'(1);
  assign mid     = lo_r + IDX_W'(span >> 1);
  assign cum_mid = zero_r ? SUM_W'(mid_r) : pram_rdata;
  assign cum_lo  = (lo_r == '0) ? '0 : (zero_r ? SUM_W'(lo_r) : pram_rdata);
  assign w_sel   = zero_r ? WEIGHT_BITS'(1) : wram_rdata;
  assign nump    = {pn_r, {FRAC_W{1'b0}}};

  // ---------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (query_acc) begin
          state_nxt = (cnt_r == '0) ? ST_OUT : ST_TGT;
        end
      end
      ST_TGT:   state_nxt = ST_SRCH;
      ST_SRCH:  state_nxt = (lo_r < hi_r) ? ST_CMP : ST_FETCH;
      ST_CMP:   state_nxt = ST_SRCH;
      ST_FETCH: state_nxt = ST_NUM;
      ST_NUM:   state_nxt = ST_DEN;
      ST_DEN:   state_nxt = ST_XST;
      ST_XST:   state_nxt = ST_XDIV;
      ST_XDIV:  state_nxt = div_rsp.done ? ST_PST : ST_XDIV;
      ST_PST:   state_nxt = zero_r ? ST_OUT : ST_PDIV;
      ST_PDIV:  state_nxt = div_rsp.done ? ST_OUT : ST_PDIV;
      ST_OUT:   state_nxt = out_ch.ready ? ST_IDLE : ST_OUT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------- control outputs
  always_comb begin
    in_ch.ready   = (state_r == ST_IDLE);
    out_ch.valid  = (state_r == ST_OUT);
    wram_raddr    = lo_r;
    pram_raddr    = lo_r - 1'b1;
    mul_a         = SUM_W'(n_r);
    mul_b         = MB_W'(w_r);
    div_req.start = 1'b0;
    div_req.steps = STEP_W'(XQ_W);
    div_rem0      = DEN_W'(numx_r >> XQ_W);
    div_low       = {numx_r[XQ_W-1:0], {(PQ_W - XQ_W){1'b0}}};
    div_den       = denx_r;
    unique case (state_r)
      ST_TGT: begin
        mul_a = zero_r ? SUM_W'(n_r) : tot_r;
        mul_b = MB_W'(u_r);
      end
      ST_SRCH: begin
        pram_raddr = mid - 1'b1;
      end
      ST_NUM: begin
        mul_a = SUM_W'(lo_r);
        mul_b = MB_W'(w_sel);
      end
      ST_XST: begin
        div_req.start = 1'b1;
        mul_b         = MB_W'(wt_r);
      end
      ST_PST: begin
        div_req.start = !zero_r;
        div_req.steps = STEP_W'(PQ_W);
        div_rem0      = DEN_W'(nump >> PQ_W);
        div_low       = nump[PQ_W-1:0];
        div_den       = DEN_W'(tot_r);
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (query_acc) begin
          u_r    <= in_ch.u;
          n_r    <= cnt_r;
          zero_r <= (tot_r == '0);
          lo_r   <= '0;
          hi_r   <= IDX_W'(cnt_r - 1'b1);
          // Empty table answers at once.
          x_r    <= '0;
          pdf_r  <= '0;
          bin_r  <= '0;
          zt_r   <= 1'b1;
        end
      end
      ST_TGT: begin
        tgt_r <= TGT_W'(mul_p);
        zt_r  <= zero_r;
      end
      ST_SRCH: begin
        mid_r <= mid;
        bin_r <= BIN_W'(lo_r);
      end
      ST_CMP: begin
        if ({cum_mid, {FRAC_W{1'b0}}} <= tgt_r) begin
          lo_r <= mid_r;
        end else begin
          hi_r <= mid_r - 1'b1;
        end
      end
      ST_NUM: begin
        w_r   <= w_sel;
        wt_r  <= wram_rdata;
        num_r <= tgt_r - {cum_lo, {FRAC_W{1'b0}}};
        lw_r  <= SUM_W'(mul_p);
      end
      ST_DEN: begin
        if (w_r == '0) begin
          denx_r <= DEN_W'(n_r);
          numx_r <= NUM_W'({lo_r, {FRAC_W{1'b0}}});
        end else begin
          denx_r <= DEN_W'(mul_p);
          numx_r <= NUM_W'({lw_r, {FRAC_W{1'b0}}}) + NUM_W'(num_r);
        end
      end
      ST_XST: begin
        pn_r <= DEN_W'(mul_p);
      end
      ST_XDIV: begin
        if (div_rsp.done) begin
          x_r <= (|div_q[PQ_W-1:FRAC_W]) ? '1 : div_q[FRAC_W-1:0];
        end
      end
      ST_PST: begin
        pdf_r <= '0;
      end
      ST_PDIV: begin
        if (div_rsp.done) begin
          pdf_r <= PDF_W'(div_q);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.x          = x_r;
  assign out_ch.pdf        = pdf_r;
  assign out_ch.bin        = bin_r;
  assign out_ch.zero_total = zt_r;

  `PCCS_ASSERT_IMP(a_mid_in_range, state_r == ST_CMP, mid_r > lo_r && mid_r <= hi_r, "search midpoint outside bounds")
  `PCCS_ASSERT_IMP(a_bounds_ordered, state_r == ST_SRCH, lo_r <= hi_r && CNT_W'(hi_r) < n_r, "search bounds crossed")
  `PCCS_ASSERT_IMP(a_div_done_waited, div_rsp.done, state_r == ST_XDIV || state_r == ST_PDIV, "divider finished outside a wait state")
  `PCCS_ASSERT_NXT(a_query_starts, query_acc, state_r == ST_TGT || state_r == ST_OUT, "query beat did not start a query")

endmodule
